// File: src/checked_radio_frame_deframer_unit_assert.svh
// assertion helpers shared by the deframer modules
`ifndef CHECKED_RADIO_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define CHECKED_RADIO_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CRFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/crfd_pkg.sv
package crfd_pkg;

	localparam int HEADER_BYTES = 8;

	// fixed frame positions inside the header
	localparam int POS_IDLE  = 0;
	localparam int POS_SYNC2 = 1;
	localparam int POS_DIR   = 2;
	localparam int POS_CMD   = 3;
	localparam int POS_LENH  = 4;
	localparam int POS_LENL  = 5;
	localparam int POS_HCKA  = 6;
	localparam int POS_HCKB  = 7;

	localparam logic [7:0] SYNC1_RST    = 8'd72;
	localparam logic [7:0] SYNC2_RST    = 8'd101;
	localparam logic [7:0] INBOUND_RST  = 8'd16;
	localparam logic [7:0] OUTBOUND_RST = 8'd32;

	localparam logic [7:0] DIGIT_LO = 8'h30;
	localparam logic [7:0] DIGIT_HI = 8'h39;

	typedef enum logic [1:0] {
		CFG_SYNC1    = 2'd0,
		CFG_SYNC2    = 2'd1,
		CFG_INBOUND  = 2'd2,
		CFG_OUTBOUND = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		EV_PAYLOAD     = 3'd0,
		EV_GOOD        = 3'd1,
		EV_HEADER_ERR  = 3'd2,
		EV_PAYLOAD_BAD = 3'd3,
		EV_TOO_LONG    = 3'd4
	} ev_kind_t;

	typedef struct packed {
		logic [7:0] sync1;
		logic [7:0] sync2;
		logic [7:0] inbound;
		logic [7:0] outbound;
	} cfg_t;

	typedef struct packed {
		logic       hit;
		ev_kind_t   kind;
		logic [7:0] data;
		logic [7:0] cmd;
		logic [9:0] len;
	} res_t;

	// ascii digits stand for their value, anything else for itself
	function automatic logic [7:0] digit_map(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= DIGIT_LO && b <= DIGIT_HI) begin
			r = b - DIGIT_LO;
		end
		return r;
	endfunction

endpackage

// File: src/checked_radio_frame_deframer_unit.sv
// Received radio bytes enter one per beat on the in channel and are checked against the
// frame layout: two sync bytes, direction, command, two length bytes, a two-byte header
// Fletcher-8 check, the payload and a two-byte payload Fletcher-8 check. Each payload byte
// leaves as its own result beat, and one status beat (good, payload check bad, header
// error or length too large) closes every frame that reaches its header check unless a
// byte equal to the first sync register, which restarts framing anywhere, comes first.
// Bytes are taken one per clock while the result register is free, passing the input
// register, frame step and result register. The user writes registers via the cfg port
// only while no byte is in flight (unenforced); they hold reset values until then.
module checked_radio_frame_deframer_unit #(
	parameter int MAX_PAYLOAD = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_kind,
	output logic [7:0] data_byte,
	output logic [7:0] frame_command,
	output logic [9:0] frame_length
);
	import crfd_pkg::*;

	`include "checked_radio_frame_deframer_unit_assert.svh"

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	res_t       out_q;
	logic       out_free;
	logic       step;

	crfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the result slot frees when empty or taken this cycle
	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	crfd_parse #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_b   (byte_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = out_q.kind;
	assign data_byte     = out_q.data;
	assign frame_command = out_q.cmd;
	assign frame_length  = out_q.len;

	// only payload beats carry a data byte
	`CRFD_ASSERT_NOW(a_data_zero, out_valid_q && out_q.kind != EV_PAYLOAD, out_q.data == 8'd0, "status beat with nonzero data")
	// an oversize frame reports no length
	`CRFD_ASSERT_NOW(a_too_long_len, out_valid_q && out_q.kind == EV_TOO_LONG, out_q.len == 10'd0, "length too large beat with length")
	// a byte waiting on a full result slot is held
	`CRFD_ASSERT_NEXT(a_s1_hold, valid_s1 && !out_free, valid_s1 && $stable(byte_s1), "input register lost a stalled byte")

endmodule

// File: src/crfd_cfg.sv
module crfd_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output crfd_pkg::cfg_t     cfg
);
	import crfd_pkg::*;

	cfg_t cfg_q;

	// register file, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync1    <= SYNC1_RST;
			cfg_q.sync2    <= SYNC2_RST;
			cfg_q.inbound  <= INBOUND_RST;
			cfg_q.outbound <= OUTBOUND_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SYNC1:    cfg_q.sync1    <= cfg_data;
				CFG_SYNC2:    cfg_q.sync2    <= cfg_data;
				CFG_INBOUND:  cfg_q.inbound  <= cfg_data;
				CFG_OUTBOUND: cfg_q.outbound <= cfg_data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/crfd_parse.sv
module crfd_parse #(
	parameter int MAX_PAYLOAD = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_b,
	input  crfd_pkg::cfg_t cfg,
	output crfd_pkg::res_t res
);
	import crfd_pkg::*;

	`include "checked_radio_frame_deframer_unit_assert.svh"

	localparam int POS_W = $clog2(MAX_PAYLOAD + HEADER_BYTES + 3);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       sum_lo_q, sum_lo_d;
	logic [7:0]       sum_hi_q, sum_hi_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [15:0]      len_q, len_d;
	logic             chk_ok_q, chk_ok_d;

	logic [7:0]       lo_acc, hi_acc, head_hi;
	logic [9:0]       len10;
	logic [POS_W-1:0] end_pos, pos_inc;
	logic             hdr_ok;

	// running fletcher sums with the current byte folded in
	assign lo_acc  = sum_lo_q + rx_b;
	assign hi_acc  = sum_hi_q + lo_acc;
	assign head_hi = sum_hi_q - sum_lo_q;
	assign hdr_ok  = chk_ok_q && (rx_b == head_hi);
	assign len10   = len_q[9:0];
	assign end_pos = POS_W'(HEADER_BYTES) + POS_W'(len10);
	assign pos_inc = pos_q + POS_W'(1);

	// per-byte frame step
	always_comb begin
		pos_d    = pos_q;
		sum_lo_d = sum_lo_q;
		sum_hi_d = sum_hi_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		chk_ok_d = chk_ok_q;
		res      = '0;
		res.kind = EV_PAYLOAD;
		if (rx_b == cfg.sync1) begin
			// first sync byte restarts framing anywhere
			pos_d    = POS_W'(POS_SYNC2);
			sum_lo_d = '0;
			sum_hi_d = '0;
			cmd_d    = '0;
			len_d    = '0;
			chk_ok_d = 1'b0;
		end else if (pos_q == POS_W'(POS_IDLE)) begin
			pos_d = pos_q;
		end else if (pos_q == POS_W'(POS_SYNC2)) begin
			pos_d = (rx_b == cfg.sync2) ? POS_W'(POS_DIR) : POS_W'(POS_IDLE);
		end else if (pos_q == POS_W'(POS_DIR)) begin
			if (rx_b != cfg.inbound && rx_b != cfg.outbound) begin
				pos_d = POS_W'(POS_IDLE);
			end else begin
				sum_lo_d = lo_acc;
				sum_hi_d = hi_acc;
				pos_d    = POS_W'(POS_CMD);
			end
		end else if (pos_q == POS_W'(POS_CMD)) begin
			if (rx_b == 8'd0) begin
				pos_d = POS_W'(POS_IDLE);
			end else begin
				cmd_d    = digit_map(rx_b);
				sum_lo_d = lo_acc;
				sum_hi_d = hi_acc;
				pos_d    = POS_W'(POS_LENH);
			end
		end else if (pos_q == POS_W'(POS_LENH)) begin
			len_d    = {digit_map(rx_b), 8'd0};
			sum_lo_d = lo_acc;
			sum_hi_d = hi_acc;
			pos_d    = POS_W'(POS_LENL);
		end else if (pos_q == POS_W'(POS_LENL)) begin
			len_d    = {len_q[15:8], digit_map(rx_b)};
			sum_lo_d = lo_acc;
			sum_hi_d = hi_acc;
			pos_d    = POS_W'(POS_HCKA);
		end else if (pos_q == POS_W'(POS_HCKA)) begin
			chk_ok_d = (rx_b == sum_lo_q);
			sum_lo_d = lo_acc;
			sum_hi_d = hi_acc;
			pos_d    = POS_W'(POS_HCKB);
		end else if (pos_q == POS_W'(POS_HCKB)) begin
			// second header check byte is compared against sum b before check a
			sum_lo_d = lo_acc;
			sum_hi_d = hi_acc;
			if (!hdr_ok || cmd_q == 8'd0) begin
				pos_d    = POS_W'(POS_IDLE);
				res.hit  = 1'b1;
				res.kind = EV_HEADER_ERR;
			end else if (len_q > 16'(MAX_PAYLOAD)) begin
				pos_d    = POS_W'(POS_IDLE);
				res.hit  = 1'b1;
				res.kind = EV_TOO_LONG;
				res.cmd  = cmd_q;
			end else begin
				pos_d = POS_W'(HEADER_BYTES);
			end
		end else if (pos_q < end_pos) begin
			// payload byte streams straight out
			sum_lo_d = lo_acc;
			sum_hi_d = hi_acc;
			pos_d    = pos_inc;
			res.hit  = 1'b1;
			res.kind = EV_PAYLOAD;
			res.data = rx_b;
			res.cmd  = cmd_q;
			res.len  = len10;
		end else if (pos_q == end_pos) begin
			chk_ok_d = (rx_b == sum_lo_q);
			pos_d    = pos_inc;
		end else if (pos_q == end_pos + POS_W'(1)) begin
			pos_d    = POS_W'(POS_IDLE);
			res.hit  = 1'b1;
			res.kind = (chk_ok_q && rx_b == sum_hi_q) ? EV_GOOD : EV_PAYLOAD_BAD;
			res.cmd  = cmd_q;
			res.len  = len10;
		end else begin
			pos_d = POS_W'(POS_IDLE);
		end
	end

	// frame state, updated once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_lo_q <= '0;
			sum_hi_q <= '0;
			cmd_q    <= '0;
			len_q    <= '0;
			chk_ok_q <= 1'b0;
		end else if (step) begin
			pos_q    <= pos_d;
			sum_lo_q <= sum_lo_d;
			sum_hi_q <= sum_hi_d;
			cmd_q    <= cmd_d;
			len_q    <= len_d;
			chk_ok_q <= chk_ok_d;
		end
	end

	// header errors carry no command or length
	`CRFD_ASSERT_NOW(a_hdr_err_clear, res.hit && res.kind == EV_HEADER_ERR, res.cmd == 8'd0 && res.len == 10'd0, "header error with command or length")
	// a payload byte only comes out past the header with a nonzero command
	`CRFD_ASSERT_NOW(a_payload_pos, res.hit && res.kind == EV_PAYLOAD, pos_q >= POS_W'(HEADER_BYTES) && cmd_q != 8'd0, "payload beat outside payload section")
	// every closing status returns the parser to idle
	`CRFD_ASSERT_NEXT(a_close_idle, step && res.hit && res.kind != EV_PAYLOAD, pos_q == POS_W'(POS_IDLE), "parser not idle after frame status")

endmodule

// File: verif/tb_checked_radio_frame_deframer_unit.sv
`timescale 1ns / 1ps

module tb_checked_radio_frame_deframer_unit;
	import crfd_pkg::*;

	localparam int MAX_LEN = 255;

	// one expected result beat
	typedef struct {
		ev_kind_t   kind;
		logic [7:0] data;
		logic [7:0] cmd;
		logic [9:0] len;
	} frame_event_t;

	// tracks the frame state of the deframer and checks every result beat
	class frame_event_checker;
		cfg_t                regs;
		logic [10:0]         frame_pos;
		logic [7:0]          run_lo;
		logic [7:0]          run_hi;
		logic [7:0]          cmd_value;
		logic [15:0]         len_value;
		bit                  check_a_ok;
		frame_event_t        pending_events[$];
		int                  mismatches;

		function new();
			regs = '{SYNC1_RST, SYNC2_RST, INBOUND_RST, OUTBOUND_RST};
			frame_pos = '0;
			run_lo = '0;
			run_hi = '0;
			cmd_value = '0;
			len_value = '0;
			check_a_ok = 1'b0;
			mismatches = 0;
		endfunction

		// ascii digits decode to their value, other bytes pass through
		static function logic [7:0] ascii_value(logic [7:0] b);
			if (b >= DIGIT_LO && b <= DIGIT_HI) begin
				return b - DIGIT_LO;
			end
			return b;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [7:0] v);
			case (idx)
				CFG_SYNC1: regs.sync1 = v;
				CFG_SYNC2: regs.sync2 = v;
				CFG_INBOUND: regs.inbound = v;
				CFG_OUTBOUND: regs.outbound = v;
				default: regs = regs;
			endcase
		endfunction

		function void add_sum(logic [7:0] b);
			run_lo = run_lo + b;
			run_hi = run_hi + run_lo;
		endfunction

		function void push_event(ev_kind_t kind, logic [7:0] data, logic [7:0] cmd,
				logic [9:0] len);
			frame_event_t ev;
			ev.kind = kind;
			ev.data = data;
			ev.cmd = cmd;
			ev.len = len;
			pending_events.push_back(ev);
		endfunction

		// advance the frame state by one accepted rx beat
		function void note_rx_byte(logic [7:0] b);
			logic [7:0] head_b;
			logic [9:0] plen;
			bit         ok;

			// first sync byte restarts framing anywhere
			if (b == regs.sync1) begin
				frame_pos = 11'(POS_IDLE);
			end
			case (frame_pos)
				POS_IDLE: begin
					if (b == regs.sync1) begin
						run_lo = '0;
						run_hi = '0;
						cmd_value = '0;
						len_value = '0;
						check_a_ok = 1'b0;
						frame_pos = 11'(POS_SYNC2);
					end
				end
				POS_SYNC2: begin
					frame_pos = (b == regs.sync2) ? 11'(POS_DIR) : 11'(POS_IDLE);
				end
				POS_DIR: begin
					if (b != regs.inbound && b != regs.outbound) begin
						frame_pos = 11'(POS_IDLE);
					end else begin
						add_sum(b);
						frame_pos = 11'(POS_CMD);
					end
				end
				POS_CMD: begin
					if (b == 8'h00) begin
						frame_pos = 11'(POS_IDLE);
					end else begin
						cmd_value = ascii_value(b);
						add_sum(b);
						frame_pos = 11'(POS_LENH);
					end
				end
				POS_LENH: begin
					len_value = {ascii_value(b), 8'h00};
					add_sum(b);
					frame_pos = 11'(POS_LENL);
				end
				POS_LENL: begin
					len_value[7:0] = ascii_value(b);
					add_sum(b);
					frame_pos = 11'(POS_HCKA);
				end
				POS_HCKA: begin
					check_a_ok = (b == run_lo);
					add_sum(b);
					frame_pos = 11'(POS_HCKB);
				end
				POS_HCKB: begin
					// second header sum as it stood before the first check byte
					head_b = run_hi - run_lo;
					ok = check_a_ok && (b == head_b);
					add_sum(b);
					if (!ok || cmd_value == 8'h00) begin
						frame_pos = 11'(POS_IDLE);
						push_event(EV_HEADER_ERR, 8'h00, 8'h00, 10'd0);
					end else if (len_value > MAX_LEN) begin
						frame_pos = 11'(POS_IDLE);
						push_event(EV_TOO_LONG, 8'h00, cmd_value, 10'd0);
					end else begin
						frame_pos = 11'(HEADER_BYTES);
					end
				end
				default: begin
					plen = len_value[9:0];
					if (frame_pos < HEADER_BYTES + plen) begin
						add_sum(b);
						frame_pos = frame_pos + 1'b1;
						push_event(EV_PAYLOAD, b, cmd_value, plen);
					end else if (frame_pos == HEADER_BYTES + plen) begin
						check_a_ok = (b == run_lo);
						frame_pos = frame_pos + 1'b1;
					end else if (frame_pos == HEADER_BYTES + plen + 1) begin
						ok = check_a_ok && (b == run_hi);
						frame_pos = 11'(POS_IDLE);
						push_event(ok ? EV_GOOD : EV_PAYLOAD_BAD, 8'h00, cmd_value, plen);
					end else begin
						frame_pos = 11'(POS_IDLE);
					end
				end
			endcase
		endfunction

		// compare one result beat against the oldest expectation
		function void check_result(logic [2:0] kind, logic [7:0] data, logic [7:0] cmd,
				logic [9:0] len);
			frame_event_t want;
			if (pending_events.size() == 0) begin
				$display("%0t: beat expected none, actual kind %0d data %02h cmd %02h len %0d",
					$time, kind, data, cmd, len);
				mismatches++;
				return;
			end
			want = pending_events.pop_front();
			if (kind !== want.kind) begin
				$display("%0t: event_kind expected %0d actual %0d", $time, want.kind, kind);
				mismatches++;
			end
			if (data !== want.data) begin
				$display("%0t: data_byte expected %02h actual %02h", $time, want.data, data);
				mismatches++;
			end
			if (cmd !== want.cmd) begin
				$display("%0t: frame_command expected %02h actual %02h", $time, want.cmd, cmd);
				mismatches++;
			end
			if (len !== want.len) begin
				$display("%0t: frame_length expected %0d actual %0d", $time, want.len, len);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] event_kind;
	logic [7:0] data_byte;
	logic [7:0] frame_command;
	logic [9:0] frame_length;

	frame_event_checker tracker;
	cfg_t               active_cfg = '{SYNC1_RST, SYNC2_RST, INBOUND_RST, OUTBOUND_RST};
	logic [7:0]         tx_frame[$];
	int                 burst_left = 0;

	checked_radio_frame_deframer_unit #(
		.MAX_PAYLOAD(MAX_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.data_byte(data_byte),
		.frame_command(frame_command),
		.frame_length(frame_length)
	);

	always #6 clk = ~clk;

	// result side back-pressure: the mode switches at random
	int stall_mode = 0;
	int mode_left = 0;
	int run_left = 0;
	int cyc_count = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 300);
		end
		mode_left--;
		cyc_count++;
		case (stall_mode)
			0: out_ready = 1'b1;
			1: out_ready = 1'($urandom_range(0, 1));
			2: begin
				if (run_left == 0) begin
					out_ready = !out_ready;
					run_left = out_ready ? $urandom_range(1, 6) : $urandom_range(1, 20);
				end
				run_left--;
			end
			default: out_ready = (cyc_count % 4) != 3;
		endcase
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			tracker.check_result(event_kind, data_byte, frame_command, frame_length);
		end
	end

	// one rx beat, with bursty gaps in front of it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (in_ready !== 1'b1);
		tracker.note_rx_byte(b);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (tx_frame[k]) begin
			send_byte(tx_frame[k]);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		tracker.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic write_config(input cfg_t c);
		write_reg(CFG_SYNC1, c.sync1);
		write_reg(CFG_SYNC2, c.sync2);
		write_reg(CFG_INBOUND, c.inbound);
		write_reg(CFG_OUTBOUND, c.outbound);
		cfg_we = 1'b0;
		active_cfg = c;
	endtask

	// stop sending, wait for every expected beat, then let the pipe empty
	task automatic settle();
		in_valid = 1'b0;
		burst_left = 0;
		while (tracker.pending_events.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// assemble one frame with proper Fletcher checks, optionally broken
	function automatic void build_frame(logic [7:0] s2, logic [7:0] dir, logic [7:0] cmdb,
			logic [7:0] lh, logic [7:0] ll, bit hdr_bad, bit pay_bad, bit head_only,
			bit extreme_fill);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		int         plen;
		int         from;

		tx_frame.delete();
		tx_frame.push_back(active_cfg.sync1);
		tx_frame.push_back(s2);
		tx_frame.push_back(dir);
		tx_frame.push_back(cmdb);
		tx_frame.push_back(lh);
		tx_frame.push_back(ll);
		lo = '0;
		hi = '0;
		for (int k = POS_DIR; k < tx_frame.size(); k++) begin
			lo = lo + tx_frame[k];
			hi = hi + lo;
		end
		ck_a = lo;
		ck_b = hi;
		if (hdr_bad) begin
			if ($urandom_range(0, 1)) ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
			else ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
		end
		tx_frame.push_back(ck_a);
		tx_frame.push_back(ck_b);
		plen = int'({frame_event_checker::ascii_value(lh),
			frame_event_checker::ascii_value(ll)});
		if (head_only || hdr_bad || frame_event_checker::ascii_value(cmdb) == 8'h00
				|| plen > MAX_LEN) begin
			return;
		end

		// payload, then the check over everything from the direction byte on
		from = POS_HCKA;
		for (int k = 0; k < plen; k++) begin
			if (extreme_fill) tx_frame.push_back((k % 2) ? 8'hFF : 8'h00);
			else tx_frame.push_back(8'($urandom_range(0, 255)));
		end
		for (int k = from; k < tx_frame.size(); k++) begin
			lo = lo + tx_frame[k];
			hi = hi + lo;
		end
		ck_a = lo;
		ck_b = hi;
		if (pay_bad) begin
			if ($urandom_range(0, 1)) ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
			else ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
		end
		tx_frame.push_back(ck_a);
		tx_frame.push_back(ck_b);
	endfunction

	// mostly well-formed frames with random content, the rest broken or noise
	function automatic void compose_random(output bit counted);
		logic [7:0] s2;
		logic [7:0] dir;
		logic [7:0] cmdb;
		logic [7:0] lh;
		logic [7:0] ll;
		bit         hdr_bad;
		bit         pay_bad;
		bit         head_only;
		bit         cut;
		int         pick;
		int         keep;

		counted = 1'b1;
		hdr_bad = 1'b0;
		pay_bad = 1'b0;
		head_only = 1'b0;
		cut = 1'b0;
		s2 = active_cfg.sync2;
		dir = $urandom_range(0, 1) ? active_cfg.inbound : active_cfg.outbound;
		cmdb = $urandom_range(0, 1) ? DIGIT_LO + 8'($urandom_range(1, 9))
			: 8'($urandom_range(1, 255));
		lh = $urandom_range(0, 1) ? DIGIT_LO : 8'h00;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: ll = 8'($urandom_range(0, 16));
			5, 6: ll = DIGIT_LO + 8'($urandom_range(0, 9));
			7, 8: ll = 8'($urandom_range(17, 64));
			default: ll = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 255));
		endcase

		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			// well formed
		end else if (pick < 63) begin
			pay_bad = 1'b1;
		end else if (pick < 70) begin
			hdr_bad = 1'b1;
		end else if (pick < 74) begin
			// digit zero command decodes to zero
			cmdb = DIGIT_LO;
		end else if (pick < 77) begin
			cmdb = 8'h00;
		end else if (pick < 82) begin
			// length above the payload limit
			lh = 8'($urandom_range(1, 255));
			if (lh == DIGIT_LO) lh = DIGIT_LO + 8'd1;
		end else if (pick < 85) begin
			do s2 = 8'($urandom_range(0, 255)); while (s2 == active_cfg.sync2);
			head_only = 1'b1;
		end else if (pick < 88) begin
			do dir = 8'($urandom_range(0, 255));
			while (dir == active_cfg.inbound || dir == active_cfg.outbound);
			head_only = 1'b1;
		end else if (pick < 95) begin
			cut = 1'b1;
		end else begin
			tx_frame.delete();
			repeat ($urandom_range(1, 8)) tx_frame.push_back(8'($urandom_range(0, 255)));
			counted = 1'b0;
			return;
		end
		build_frame(s2, dir, cmdb, lh, ll, hdr_bad, pay_bad, head_only, 1'b0);
		if (cut && tx_frame.size() > 2) begin
			keep = $urandom_range(2, tx_frame.size() - 1);
			while (tx_frame.size() > keep) void'(tx_frame.pop_back());
		end
	endfunction

	task automatic run_random(input int target);
		int sent;
		bit counted;
		sent = 0;
		while (sent < target) begin
			compose_random(counted);
			if (counted) sent += tx_frame.size();
			send_frame();
		end
	endtask

	initial begin
		cfg_t rnd_cfg;

		tracker = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: good frame with digit command and length, bad header, too long
		build_frame(active_cfg.sync2, active_cfg.inbound, 8'h37, DIGIT_LO, DIGIT_LO + 8'd2,
			1'b0, 1'b0, 1'b0, 1'b1);
		send_frame();
		build_frame(active_cfg.sync2, active_cfg.outbound, 8'hFF, 8'h00, 8'h01,
			1'b1, 1'b0, 1'b0, 1'b0);
		send_frame();
		build_frame(active_cfg.sync2, active_cfg.inbound, 8'h01, 8'h01, 8'h00,
			1'b0, 1'b0, 1'b0, 1'b0);
		send_frame();
		run_random(400);
		settle();

		// register extremes
		write_config('{8'h00, 8'hFF, 8'hFF, 8'h01});
		run_random(300);
		settle();
		write_config('{8'hFF, 8'h00, 8'h00, 8'hFE});
		run_random(300);
		settle();

		// equal sync bytes: the second one restarts, nothing gets through
		write_config('{8'h5A, 8'h5A, 8'h10, 8'h00});
		run_random(60);
		settle();

		// random register settings
		repeat (2) begin
			rnd_cfg.sync1 = 8'($urandom_range(0, 255));
			rnd_cfg.sync2 = 8'($urandom_range(0, 255));
			rnd_cfg.inbound = 8'($urandom_range(0, 255));
			rnd_cfg.outbound = 8'($urandom_range(0, 255));
			write_config(rnd_cfg);
			run_random(220);
			settle();
		end

		if (tracker.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
